// ===== rtl/brc_pkg.sv =====
package brc_pkg;

	// Widths fixed by the row word and the register map.
	localparam int ROW_W        = 16;
	localparam int MODE_W       = 2;
	localparam int SIZE_W       = 5;
	localparam int ADDR_W       = 3;
	localparam int DATA_W       = 32;
	localparam int MAX_SIZE_DEF = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_REFLEX = 2'd0,
		MODE_TRANS  = 2'd1,
		MODE_SYM    = 2'd2,
		MODE_PASS   = 2'd3
	} closure_mode_t;

	// Register index, taken from paddr[2].
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	localparam closure_mode_t     MODE_RST = MODE_TRANS;
	localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

endpackage

// ===== rtl/binary_relation_closure_unit.sv =====
// Closure of a square 0/1 relation, one matrix row per word.
// Input channel: in_valid/in_ready carry in_row, row 0 first; bit j is column j.
// Output channel: out_valid/out_ready carry out_row and out_last, row 0 first;
// out_last marks the final row. Bits at and above the matrix size read as zero.
// Configuration: APB-style port, closure_mode at address 0 (0 reflexive,
// 1 transitive, 2 symmetric, 3 pass-through) and matrix_size at address 4.
// Write the registers only while no matrix is being loaded or processed.
// Processing: rows load at one per cycle. After the last row the
// single read/update unit runs over the work memory, each row access a read
// followed by a use of the registered data and a write-back. The result then
// drains row by row.
// in_ready stays low from the last row of a matrix until its last row leaves.
// When the receiver stalls, the current result row is held on the output
// register and the sequencer waits.
// Reset clears the load position, aborts any matrix in progress and sets
// closure_mode to transitive and matrix_size to 16. Stored rows are not cleared.
module binary_relation_closure_unit
	import brc_pkg::*;
#(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [ROW_W-1:0]  in_row,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ROW_W-1:0]  out_row,
	output logic              out_last,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

	typedef enum logic [2:0] {
		S_LOAD,
		S_COPY,
		S_PIVOT,
		S_WARSH,
		S_SYM,
		S_OUT,
		S_HOLD
	} state_t;

	state_t            state_q;
	logic              sub_q;
	logic [IDX_W-1:0]  a_q;
	logic [IDX_W-1:0]  b_q;
	logic [IDX_W-1:0]  load_count_q;
	logic [ROW_W-1:0]  pivot_q;
	logic [ROW_W-1:0]  acc_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_last_q;
	logic              out_valid_q;

	closure_mode_t     mode_q;
	logic [SIZE_W-1:0] size_q;

	logic [ROW_W-1:0]  rel_mem [MAX_SIZE];
	logic [ROW_W-1:0]  work_mem [MAX_SIZE];
	logic [ROW_W-1:0]  rel_rdata_q;
	logic [ROW_W-1:0]  work_rdata_q;
	logic [IDX_W-1:0]  rel_raddr;
	logic [IDX_W-1:0]  work_raddr;

	logic              work_we;
	logic [IDX_W-1:0]  work_waddr;
	logic [ROW_W-1:0]  work_wdata;

	logic [IDX_W-1:0]  last_idx;
	logic [ROW_W-1:0]  col_mask;
	logic [IDX_W-1:0]  load_idx;
	logic              load_done;
	logic              in_fire;
	logic              cfg_write;
	logic [ROW_W-1:0]  onehot_a;
	logic [ROW_W-1:0]  onehot_b;
	logic [ROW_W-1:0]  sym_row;
	logic [ROW_W-1:0]  acc_next;

	// Effective size: zero acts as one, anything above the depth as the depth.
	always_comb begin
		if (size_q == '0) begin
			last_idx = '0;
		end else if (int'(size_q) > MAX_SIZE) begin
			last_idx = IDX_W'(MAX_SIZE - 1);
		end else begin
			last_idx = IDX_W'(size_q - SIZE_W'(1));
		end
	end

	assign col_mask  = ~((~ROW_W'(0) << last_idx) << 1);
	assign load_idx  = (load_count_q >= last_idx) ? last_idx : load_count_q;
	assign load_done = (load_idx == last_idx);

	assign in_ready  = (state_q == S_LOAD);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_last  = out_last_q;

	assign onehot_a  = ROW_W'(1) << a_q;
	assign onehot_b  = ROW_W'(1) << b_q;

	// Symmetric pass: row a gathers column a of every row, plus its own bits.
	assign sym_row   = rel_rdata_q & col_mask;
	assign acc_next  = acc_q
		| ((|(sym_row & onehot_a)) ? onehot_b : '0)
		| ((b_q == a_q) ? sym_row : '0);

	assign rel_raddr  = (state_q == S_SYM) ? b_q : a_q;
	assign work_raddr = (state_q == S_WARSH) ? b_q : a_q;

	always_comb begin
		work_we    = 1'b0;
		work_waddr = a_q;
		work_wdata = rel_rdata_q & col_mask;
		case (state_q)
			S_COPY: begin
				work_we = sub_q;
				if (mode_q == MODE_REFLEX) begin
					work_wdata = (rel_rdata_q & col_mask) | onehot_a;
				end
			end
			S_WARSH: begin
				work_we    = sub_q && (|(work_rdata_q & onehot_a));
				work_waddr = b_q;
				work_wdata = work_rdata_q | pivot_q;
			end
			S_SYM: begin
				work_we    = sub_q && (b_q == last_idx);
				work_wdata = acc_next;
			end
			default: begin
				work_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rel_mem[load_idx] <= in_row & col_mask;
		end
		rel_rdata_q <= rel_mem[rel_raddr];
	end

	always_ff @(posedge clk) begin
		if (work_we) begin
			work_mem[work_waddr] <= work_wdata;
		end
		work_rdata_q <= work_mem[work_raddr];
	end

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RST;
			size_q <= SIZE_RST;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_MODE: mode_q <= closure_mode_t'(pwdata[MODE_W-1:0]);
				REG_SIZE: size_q <= pwdata[SIZE_W-1:0];
				default:  mode_q <= mode_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MODE: prdata = DATA_W'(mode_q);
			REG_SIZE: prdata = DATA_W'(size_q);
			default:  prdata = '0;
		endcase
	end

	// Each sequencer memory access is split by sub_q: sub_q low issues the read,
	// sub_q high uses the registered data and writes back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			sub_q        <= 1'b0;
			a_q          <= '0;
			b_q          <= '0;
			load_count_q <= '0;
			pivot_q      <= '0;
			acc_q        <= '0;
			out_row_q    <= '0;
			out_last_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						if (load_done) begin
							load_count_q <= '0;
							a_q          <= '0;
							b_q          <= '0;
							sub_q        <= 1'b0;
							acc_q        <= '0;
							state_q      <= (mode_q == MODE_SYM) ? S_SYM : S_COPY;
						end else begin
							load_count_q <= load_idx + IDX_W'(1);
						end
					end
				end
				S_COPY: begin
					if (!sub_q) begin
						sub_q <= 1'b1;
					end else begin
						sub_q <= 1'b0;
						if (a_q == last_idx) begin
							a_q     <= '0;
							state_q <= (mode_q == MODE_TRANS) ? S_PIVOT : S_OUT;
						end else begin
							a_q <= a_q + IDX_W'(1);
						end
					end
				end
				S_PIVOT: begin
					if (!sub_q) begin
						sub_q <= 1'b1;
					end else begin
						sub_q   <= 1'b0;
						pivot_q <= work_rdata_q;
						b_q     <= '0;
						state_q <= S_WARSH;
					end
				end
				S_WARSH: begin
					if (!sub_q) begin
						sub_q <= 1'b1;
					end else begin
						sub_q <= 1'b0;
						if (b_q == last_idx) begin
							b_q <= '0;
							if (a_q == last_idx) begin
								a_q     <= '0;
								state_q <= S_OUT;
							end else begin
								a_q     <= a_q + IDX_W'(1);
								state_q <= S_PIVOT;
							end
						end else begin
							b_q <= b_q + IDX_W'(1);
						end
					end
				end
				S_SYM: begin
					if (!sub_q) begin
						sub_q <= 1'b1;
					end else begin
						sub_q <= 1'b0;
						if (b_q == last_idx) begin
							acc_q <= '0;
							b_q   <= '0;
							if (a_q == last_idx) begin
								a_q     <= '0;
								state_q <= S_OUT;
							end else begin
								a_q <= a_q + IDX_W'(1);
							end
						end else begin
							acc_q <= acc_next;
							b_q   <= b_q + IDX_W'(1);
						end
					end
				end
				S_OUT: begin
					if (!sub_q) begin
						sub_q <= 1'b1;
					end else begin
						sub_q       <= 1'b0;
						out_row_q   <= work_rdata_q;
						out_last_q  <= (a_q == last_idx);
						out_valid_q <= 1'b1;
						state_q     <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							a_q     <= '0;
							state_q <= S_LOAD;
						end else begin
							a_q     <= a_q + IDX_W'(1);
							state_q <= S_OUT;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result word is pending");

	a_reload_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && out_last) |=> in_ready)
		else $error("not ready for a new matrix after the final result word");

	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> (load_count_q == '0))
		else $error("load position not cleared while processing a matrix");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import brc_pkg::*;

	localparam logic [ADDR_W-1:0] MODE_ADDR = {REG_MODE, 2'b00};
	localparam logic [ADDR_W-1:0] SIZE_ADDR = {REG_SIZE, 2'b00};
	localparam int SETTLE_CYCLES = 20;
	localparam int DRAIN_CYCLES  = 700;
	localparam int LONG_HOLD     = 400;
	localparam int RANDOM_ROWS   = 56;
	localparam int STALL_LEVELS [5] = '{0, 0, 30, 60, 85};

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic             last;
	} closed_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [ROW_W-1:0]  in_row = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [ROW_W-1:0]  out_row;
	logic              out_last;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Expected closed rows, oldest first, and the closure state mirrored here.
	closed_row_t       closed_rows_q [$];
	closure_mode_t     cfg_mode;
	logic [SIZE_W-1:0] cfg_size;
	logic [ROW_W-1:0]  stored_rows [MAX_SIZE_DEF];
	int                load_pos;

	int mismatch_cnt = 0;
	int rows_seen = 0;
	int burst_left = 0;
	bit bursty = 1'b1;

	logic [7:0] hold_token = '0;
	logic [7:0] hold_seen = '0;
	int         hold_left = 0;
	int         pattern_left = 0;
	int         stall_pct = 0;

	binary_relation_closure_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_row   (in_row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_row  (out_row),
		.out_last (out_last),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	function automatic void note_mismatch(input string what);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) $display("%s", what);
	endfunction

	// Stores one accepted row; once the matrix is complete, closes it and queues
	// every closed row.
	function automatic void predict_closure(input logic [ROW_W-1:0] r);
		int n;
		int idx;
		logic [ROW_W-1:0] mask;
		logic [ROW_W-1:0] work [MAX_SIZE_DEF];
		logic [ROW_W-1:0] tr [MAX_SIZE_DEF];
		closed_row_t e;
		n = (cfg_size == 0) ? 1 : ((cfg_size > MAX_SIZE_DEF) ? MAX_SIZE_DEF : int'(cfg_size));
		mask = ROW_W'((32'd1 << n) - 1);
		idx = (load_pos >= n) ? n - 1 : load_pos;
		stored_rows[idx] = r & mask;
		if (idx + 1 < n) begin
			load_pos = idx + 1;
			return;
		end
		load_pos = 0;
		for (int i = 0; i < n; i++) work[i] = stored_rows[i] & mask;
		case (cfg_mode)
			MODE_REFLEX: begin
				for (int i = 0; i < n; i++) work[i][i] = 1'b1;
			end
			MODE_TRANS: begin
				for (int k = 0; k < n; k++)
					for (int i = 0; i < n; i++)
						if (work[i][k]) work[i] |= work[k];
			end
			MODE_SYM: begin
				for (int i = 0; i < n; i++) begin
					tr[i] = '0;
					for (int j = 0; j < n; j++)
						if (work[j][i]) tr[i][j] = 1'b1;
				end
				for (int i = 0; i < n; i++) work[i] |= tr[i];
			end
			default: ;
		endcase
		for (int i = 0; i < n; i++) begin
			e.row = work[i] & mask;
			e.last = (i == n - 1);
			closed_rows_q.push_back(e);
		end
	endfunction

	function automatic logic [ROW_W-1:0] rand_row();
		case ($urandom_range(0, 5))
			0: rand_row = '0;
			1: rand_row = '1;
			2, 3: rand_row = ROW_W'($urandom() & $urandom() & $urandom());
			default: rand_row = ROW_W'($urandom());
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] rand_size();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) rand_size = SIZE_W'($urandom_range(1, 5));
		else if (pick < 85) rand_size = SIZE_W'($urandom_range(6, 15));
		else if (pick < 93) rand_size = SIZE_W'(MAX_SIZE_DEF);
		else if (pick < 97) rand_size = SIZE_W'($urandom_range(17, 31));
		else rand_size = '0;
	endfunction

	// Sends one row word and returns at the edge where it is accepted, with
	// in_valid still high.
	task automatic send_row(input logic [ROW_W-1:0] r);
		if (bursty) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				burst_left = $urandom_range(1, 8);
			end
			burst_left--;
		end
		in_valid <= 1'b1;
		in_row <= r;
		do @(posedge clk); while (!in_ready);
		predict_closure(r);
	endtask

	task automatic send_matrix_rest();
		do send_row(rand_row()); while (load_pos != 0);
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		while (closed_rows_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			note_mismatch($sformatf("register read at %0d: expected %h, got %h",
				addr, want, prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == MODE_ADDR) cfg_mode = closure_mode_t'(value[MODE_W-1:0]);
		else cfg_size = value[SIZE_W-1:0];
		@(posedge clk);
		check_reg(addr, (addr == MODE_ADDR) ? DATA_W'(cfg_mode) : DATA_W'(cfg_size));
	endtask

	// Reset values, then a size above the maximum, which must act as a full
	// 16 x 16 matrix under the reset mode.
	task automatic test_reset_and_oversize();
		check_reg(MODE_ADDR, DATA_W'(MODE_RST));
		@(posedge clk);
		check_reg(SIZE_ADDR, DATA_W'(SIZE_RST));
		@(posedge clk);
		write_reg(SIZE_ADDR, 32'd31);
		for (int i = 0; i < MAX_SIZE_DEF; i++) begin
			if (i == 10) send_row(16'hFFFF);
			else if (i == MAX_SIZE_DEF - 1) send_row(16'h0000);
			else send_row(ROW_W'(1) << (i + 1));
		end
		settle_idle();
	endtask

	// Bits at and above the matrix size must be dropped on the way in.
	task automatic test_reflexive_high_columns();
		write_reg(MODE_ADDR, DATA_W'(MODE_REFLEX));
		write_reg(SIZE_ADDR, 32'd3);
		send_row(16'hFFF8);
		send_row(16'h8002);
		send_row(16'h0005);
		settle_idle();
	endtask

	task automatic test_symmetric();
		write_reg(MODE_ADDR, DATA_W'(MODE_SYM));
		write_reg(SIZE_ADDR, 32'd4);
		send_row(16'h0002);
		send_row(16'h0004);
		send_row(16'h0008);
		send_row(16'h00F0);
		settle_idle();
	endtask

	task automatic test_pass_through();
		write_reg(MODE_ADDR, DATA_W'(MODE_PASS));
		write_reg(SIZE_ADDR, 32'd2);
		send_row(16'hFFFF);
		send_row(16'h0001);
		settle_idle();
	endtask

	task automatic test_size_zero();
		write_reg(MODE_ADDR, DATA_W'(MODE_TRANS));
		write_reg(SIZE_ADDR, 32'd0);
		send_row(16'hFFFF);
		settle_idle();
	endtask

	// Shrinking below the load position makes the next word the last row.
	task automatic test_size_shrink_mid_load();
		write_reg(MODE_ADDR, DATA_W'(MODE_TRANS));
		write_reg(SIZE_ADDR, 32'd5);
		send_row(16'h0002);
		send_row(16'h0004);
		send_row(16'h0008);
		settle_idle();
		write_reg(SIZE_ADDR, 32'd2);
		send_row(16'h0001);
		settle_idle();
	endtask

	// Growing keeps rows already loaded, masked to the size they came in with.
	task automatic test_size_grow_mid_load();
		write_reg(MODE_ADDR, DATA_W'(MODE_SYM));
		write_reg(SIZE_ADDR, 32'd2);
		send_row(16'hFFFF);
		settle_idle();
		write_reg(SIZE_ADDR, 32'd4);
		send_row(16'h0004);
		send_row(16'h0008);
		send_row(16'h0001);
		settle_idle();
	endtask

	// The receiver holds off while whole matrices keep coming, so the block
	// fills up and drops in_ready.
	task automatic test_back_pressure();
		write_reg(MODE_ADDR, DATA_W'(MODE_TRANS));
		write_reg(SIZE_ADDR, 32'd4);
		bursty = 1'b0;
		hold_token <= hold_token + 8'd1;
		repeat (3) send_matrix_rest();
		bursty = 1'b1;
		settle_idle();
	endtask

	task automatic test_random_traffic();
		int sent;
		int cut;
		logic [DATA_W-1:0] upper;
		sent = 0;
		while (sent < RANDOM_ROWS) begin
			settle_idle();
			bursty = ($urandom_range(0, 3) != 0);
			upper = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom()) : '0;
			write_reg(MODE_ADDR, (upper & ~DATA_W'(3)) | DATA_W'($urandom_range(0, 3)));
			write_reg(SIZE_ADDR, (upper & ~DATA_W'(31)) | DATA_W'(rand_size()));
			repeat ($urandom_range(1, 3)) begin
				// Now and then the size changes while a matrix is half loaded.
				cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
				for (int i = 0; i < cut; i++) begin
					send_row(rand_row());
					sent++;
				end
				if (cut != 0 && load_pos != 0) begin
					settle_idle();
					write_reg(SIZE_ADDR, DATA_W'(rand_size()));
				end
				if (load_pos != 0 || cut == 0) begin
					do begin
						send_row(rand_row());
						sent++;
					end while (load_pos != 0);
				end
			end
		end
		settle_idle();
	endtask

	// Receiver: stall level is redrawn whenever the pattern counter runs out, with a long hold on request.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= LONG_HOLD;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			if (pattern_left == 0) begin
				pattern_left <= 64;
				stall_pct <= STALL_LEVELS[$urandom_range(0, 4)];
			end else begin
				pattern_left <= pattern_left - 1;
			end
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		closed_row_t e;
		if (arst_n && out_valid && out_ready) begin
			if (closed_rows_q.size() == 0) begin
				note_mismatch($sformatf("unexpected result word %0d: row %h last %b",
					rows_seen, out_row, out_last));
			end else begin
				e = closed_rows_q.pop_front();
				if (out_row !== e.row)
					note_mismatch($sformatf("result %0d out_row: expected %h, got %h",
						rows_seen, e.row, out_row));
				if (out_last !== e.last)
					note_mismatch($sformatf("result %0d out_last: expected %b, got %b",
						rows_seen, e.last, out_last));
			end
			rows_seen++;
		end
	end

	initial begin
		cfg_mode = MODE_RST;
		cfg_size = SIZE_RST;
		load_pos = 0;
		foreach (stored_rows[i]) stored_rows[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_and_oversize();
		test_reflexive_high_columns();
		test_symmetric();
		test_pass_through();
		test_size_zero();
		test_size_shrink_mid_load();
		test_size_grow_mid_load();
		test_back_pressure();
		test_random_traffic();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
